// ===== rtl/epfbm_pkg.sv =====
// Shared types and constants for the edge period frequency bar meter.
`timescale 1ns / 1ps

package epfbm_pkg;

	// Fixed field widths.
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned STAMP_W   = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned FREQ_W    = 18;
	localparam int unsigned BAR_OUT_W = 16;
	localparam int unsigned EDGES_W   = 5;
	localparam int unsigned HZ_W      = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 10;
	localparam int unsigned FRAC_W    = 8;
	localparam int unsigned TDATA_IN_W  = 32;
	localparam int unsigned TDATA_OUT_W = 40;

	localparam logic [FREQ_W-1:0] FREQ_Q8_MAX = {FREQ_W{1'b1}};

	// Reset values of the configuration registers.
	localparam logic [EDGES_W-1:0] EDGES_RST  = 5'd10;
	localparam logic [HZ_W-1:0]    MAX_RST    = 10'd400;
	localparam logic [HZ_W-1:0]    MIN_RST    = 10'd75;
	localparam logic [HZ_W-1:0]    CENTER_RST = 10'd200;

	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_EDGE  = 2'd1,
		KIND_EVAL  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_HIGH  = 2'd1,
		STAT_LOW   = 2'd2,
		STAT_NOSIG = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGES  = 2'd0,
		REG_MAX    = 2'd1,
		REG_MIN    = 2'd2,
		REG_CENTER = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Result of the serial divider: the low quotient bits, a flag for any
	// higher quotient bit, and whether the final remainder is zero.
	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] quot;
		logic              ovf;
		logic              rem_zero;
	} div_res_t;

	typedef struct packed {
		status_t              status;
		logic [FREQ_W-1:0]    freq;
		logic [BAR_OUT_W-1:0] bar;
		logic                 updated;
	} grade_t;

endpackage

// ===== rtl/edge_period_frequency_bar_meter.sv =====
// An evaluate with a latched nonzero period runs the bit-serial divider, one quotient
// bit per cycle, over DW bits, where DW is the bit width of 31*TICKS_PER_SECOND plus
// eight (33 by default); other evaluates skip it. Input is held off until the result
// word is loaded into the output register, so the next word follows in the cycle after;
// start, edge and no-operation words leave the meter idle.
// Reset is asynchronous and active low; it restores register defaults and idle state.
`timescale 1ns / 1ps

module edge_period_frequency_bar_meter #(
	parameter int unsigned TICKS_PER_SECOND = 1000000,
	parameter int unsigned BAR_WIDTH        = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [31:0] timestamp_us
	input  logic [epfbm_pkg::TDATA_IN_W-1:0]      s_tdata,
	// [1:0] kind
	input  logic [epfbm_pkg::KIND_W-1:0]          s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [17:0] frequency_q8, [33:18] bar_pattern, [34] bar_updated, [39:35] zero
	output logic [epfbm_pkg::TDATA_OUT_W-1:0]     m_tdata,
	// [1:0] status
	output logic [epfbm_pkg::STATUS_W-1:0]        m_tuser,
	input  logic                                  cfg_we,
	input  logic [epfbm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [epfbm_pkg::CFG_DAT_W-1:0]       cfg_data
);

	localparam int unsigned NW = $clog2(31 * TICKS_PER_SECOND + 1);
	localparam int unsigned FW = epfbm_pkg::FRAC_W;
	localparam int unsigned DW = NW + FW;
	localparam int unsigned SW = epfbm_pkg::STAMP_W;
	localparam int unsigned EW = epfbm_pkg::EDGES_W;
	localparam int unsigned HW = epfbm_pkg::HZ_W;
	localparam int unsigned BW = epfbm_pkg::BAR_OUT_W;
	localparam int unsigned QW = epfbm_pkg::FREQ_W;
	localparam int unsigned PADW = epfbm_pkg::TDATA_OUT_W - QW - BW - 1;
	localparam logic [NW-1:0] TPS_N = NW'(TICKS_PER_SECOND);

	// Configuration registers.
	logic [EW-1:0] edges_q;
	logic [HW-1:0] max_q;
	logic [HW-1:0] min_q;
	logic [HW-1:0] center_q;

	// Measurement state.
	logic          awaiting_q;
	logic          done_q;
	logic [EW-1:0] ecount_q;
	logic [SW-1:0] start_q;
	logic [SW-1:0] period_q;
	logic [BW-1:0] last_bar_q;

	epfbm_pkg::state_t  state_q;
	epfbm_pkg::state_t  state_next;
	epfbm_pkg::status_t imm_status_q;
	logic               use_div_q;

	logic                          m_tvalid_q;
	logic [epfbm_pkg::TDATA_OUT_W-1:0] m_tdata_q;
	logic [epfbm_pkg::STATUS_W-1:0]    m_tuser_q;

	logic               accept;
	epfbm_pkg::kind_t   kind;
	logic [SW-1:0]      stamp;
	logic               out_free;
	logic               div_start;
	logic               emit_fire;
	logic [EW-1:0]      ecount_inc;
	logic [NW-1:0]      n_w;
	epfbm_pkg::div_res_t div_res;
	epfbm_pkg::grade_t   div_grade;
	epfbm_pkg::grade_t   emit_grade;

	assign kind       = epfbm_pkg::kind_t'(s_tuser);
	assign stamp      = s_tdata[SW-1:0];
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign ecount_inc = ecount_q + 1'b1;
	assign n_w        = NW'(edges_q) * TPS_N;

	epfbm_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({n_w, {FW{1'b0}}}),
		.divisor  (period_q),
		.res      (div_res)
	);

	epfbm_grade #(
		.BAR_WIDTH(BAR_WIDTH)
	) u_grade (
		.res       (div_res),
		.max_hz    (max_q),
		.min_hz    (min_q),
		.center_hz (center_q),
		.last_bar  (last_bar_q),
		.grade     (div_grade)
	);

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			epfbm_pkg::ST_IDLE: begin
				if (accept && (kind == epfbm_pkg::KIND_EVAL)) begin
					state_next = div_start ? epfbm_pkg::ST_DIV : epfbm_pkg::ST_EMIT;
				end
			end
			epfbm_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_next = epfbm_pkg::ST_EMIT;
				end
			end
			epfbm_pkg::ST_EMIT: begin
				if (out_free) begin
					state_next = epfbm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = epfbm_pkg::ST_IDLE;
			end
		endcase
	end

	// State machine outputs.
	always_comb begin
		s_tready  = 1'b0;
		emit_fire = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			epfbm_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && (kind == epfbm_pkg::KIND_EVAL)
					&& done_q && (period_q != '0);
			end
			epfbm_pkg::ST_EMIT: begin
				emit_fire = out_free;
			end
			default: begin
			end
		endcase
	end

	// Result of an evaluate: the graded division, or a fixed result when no division is needed.
	always_comb begin
		if (use_div_q) begin
			emit_grade = div_grade;
		end else begin
			emit_grade.status  = imm_status_q;
			emit_grade.freq    = (imm_status_q == epfbm_pkg::STAT_HIGH)
				? epfbm_pkg::FREQ_Q8_MAX : '0;
			emit_grade.bar     = last_bar_q;
			emit_grade.updated = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= epfbm_pkg::ST_IDLE;
			edges_q      <= epfbm_pkg::EDGES_RST;
			max_q        <= epfbm_pkg::MAX_RST;
			min_q        <= epfbm_pkg::MIN_RST;
			center_q     <= epfbm_pkg::CENTER_RST;
			awaiting_q   <= 1'b0;
			done_q       <= 1'b1;
			ecount_q     <= '0;
			start_q      <= '0;
			period_q     <= '0;
			last_bar_q   <= '0;
			use_div_q    <= 1'b0;
			imm_status_q <= epfbm_pkg::STAT_OK;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				unique case (epfbm_pkg::cfg_reg_t'(cfg_index))
					epfbm_pkg::REG_EDGES:  edges_q  <= cfg_data[EW-1:0];
					epfbm_pkg::REG_MAX:    max_q    <= cfg_data[HW-1:0];
					epfbm_pkg::REG_MIN:    min_q    <= cfg_data[HW-1:0];
					epfbm_pkg::REG_CENTER: center_q <= cfg_data[HW-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				case (kind)
					epfbm_pkg::KIND_START: begin
						done_q     <= 1'b0;
						awaiting_q <= 1'b1;
						period_q   <= '0;
						ecount_q   <= '0;
					end
					epfbm_pkg::KIND_EDGE: begin
						if (awaiting_q) begin
							start_q    <= stamp;
							awaiting_q <= 1'b0;
						end else if (!done_q) begin
							ecount_q <= ecount_inc;
							if (ecount_inc == edges_q) begin
								period_q <= stamp - start_q;
								done_q   <= 1'b1;
							end
						end
					end
					epfbm_pkg::KIND_EVAL: begin
						use_div_q <= div_start;
						if (!done_q) begin
							imm_status_q <= awaiting_q ? epfbm_pkg::STAT_NOSIG
								: epfbm_pkg::STAT_LOW;
						end else begin
							// A zero period reads as an unbounded frequency.
							imm_status_q <= epfbm_pkg::STAT_HIGH;
						end
					end
					default: begin
					end
				endcase
			end
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
				last_bar_q <= emit_grade.bar;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tdata_q <= {{PADW{1'b0}}, emit_grade.updated, emit_grade.bar, emit_grade.freq};
			m_tuser_q <= emit_grade.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_updated_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[QW+BW]) |-> (m_tuser == epfbm_pkg::STAT_OK))
		else $error("bar marked updated on a word that is not in range");

	a_nosig_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == epfbm_pkg::STAT_NOSIG)) |-> (m_tdata[QW-1:0] == '0))
		else $error("no-signal word carries a frequency");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == epfbm_pkg::ST_DIV))
		else $error("divider finished outside the division state");

	a_bar_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(last_bar_q))
		else $error("held bar word has more than one bit set");

	a_period_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> (period_q == '0))
		else $error("period latched while the measurement is still open");
`endif

endmodule

// ===== rtl/epfbm_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
`timescale 1ns / 1ps

module epfbm_div #(
	parameter int unsigned DW = 33
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [DW-1:0]                     dividend,
	input  logic [epfbm_pkg::STAMP_W-1:0]     divisor,
	output epfbm_pkg::div_res_t               res
);

	localparam int unsigned CW = $clog2(DW + 1);
	localparam int unsigned PW = epfbm_pkg::STAMP_W;
	localparam int unsigned QW = epfbm_pkg::FREQ_W;

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] dsr_q;
	logic [DW-1:0] dvd_q;
	logic [QW-1:0] quot_q;
	logic          ovf_q;

	logic [PW:0]   shifted;
	logic [PW:0]   diff;
	logic          ge;
	logic [PW-1:0] rem_next;

	always_comb begin
		shifted  = {rem_q, dvd_q[DW-1]};
		diff     = shifted - {1'b0, dsr_q};
		ge       = (shifted >= {1'b0, dsr_q});
		rem_next = ge ? diff[PW-1:0] : shifted[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dsr_q  <= divisor;
			dvd_q  <= dividend;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			dvd_q  <= {dvd_q[DW-2:0], 1'b0};
			// Any quotient bit above the kept window saturates the result.
			quot_q <= {quot_q[QW-2:0], ge};
			ovf_q  <= ovf_q | quot_q[QW-1];
		end
	end

	assign res.done     = done_q;
	assign res.quot     = quot_q;
	assign res.ovf      = ovf_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

// ===== rtl/epfbm_grade.sv =====
// Limit checks and bar position from the Q8 quotient of the division.
`timescale 1ns / 1ps

module epfbm_grade #(
	parameter int unsigned BAR_WIDTH = 16
) (
	input  epfbm_pkg::div_res_t                 res,
	input  logic [epfbm_pkg::HZ_W-1:0]          max_hz,
	input  logic [epfbm_pkg::HZ_W-1:0]          min_hz,
	input  logic [epfbm_pkg::HZ_W-1:0]          center_hz,
	input  logic [epfbm_pkg::BAR_OUT_W-1:0]     last_bar,
	output epfbm_pkg::grade_t                   grade
);

	localparam int unsigned HW = epfbm_pkg::HZ_W;
	localparam int unsigned FW = epfbm_pkg::FRAC_W;
	localparam int unsigned MW = HW + 1;
	localparam int unsigned PSW = HW + 2;
	localparam int unsigned CP = BAR_WIDTH / 2 - 1;

	logic [HW-1:0]  q;
	logic [FW-1:0]  qlow;
	logic           rem_nz;
	logic           too_high;
	logic           too_low;
	logic           round_up;
	logic [HW-1:0]  delta;
	logic [MW-1:0]  mag;
	logic [PSW-1:0] pos;
	logic           on_scale;
	logic [epfbm_pkg::BAR_OUT_W-1:0] bar_new;

	always_comb begin
		q        = res.quot[epfbm_pkg::FREQ_W-1:FW];
		qlow     = res.quot[FW-1:0];
		// The fractional part n/p - q is zero only when both the low quotient
		// bits and the remainder are zero.
		rem_nz   = (qlow != '0) || !res.rem_zero;
		too_high = res.ovf || (q > max_hz) || ((q == max_hz) && rem_nz);
		too_low  = (q < min_hz);
		delta    = '0;
		mag      = '0;
		pos      = '0;
		on_scale = 1'b0;
		round_up = 1'b0;
		if (q >= center_hz) begin
			// At or above the centre: round half up on the fraction.
			delta    = q - center_hz;
			mag      = {1'b0, delta} + MW'(qlow[FW-1]);
			pos      = PSW'(CP) + {1'b0, mag};
			on_scale = 1'b1;
		end else begin
			// Below the centre the fraction is taken from the next whole
			// step down, so a half rounds away from the centre.
			delta    = center_hz - q;
			round_up = (qlow < {1'b1, {(FW-1){1'b0}}})
				|| ((qlow == {1'b1, {(FW-1){1'b0}}}) && res.rem_zero);
			if (rem_nz) begin
				mag = {1'b0, delta - 1'b1} + MW'(round_up);
			end else begin
				mag = {1'b0, delta};
			end
			on_scale = (mag <= MW'(CP));
			pos      = PSW'(CP) - {1'b0, mag};
		end
		if ((pos >= PSW'(BAR_WIDTH)) || (pos >= PSW'(epfbm_pkg::BAR_OUT_W))) begin
			on_scale = 1'b0;
		end
		bar_new = on_scale
			? (epfbm_pkg::BAR_OUT_W'(1) << pos[$clog2(epfbm_pkg::BAR_OUT_W)-1:0])
			: '0;

		grade.freq    = res.ovf ? epfbm_pkg::FREQ_Q8_MAX : res.quot;
		grade.bar     = last_bar;
		grade.updated = 1'b0;
		if (too_high) begin
			grade.status = epfbm_pkg::STAT_HIGH;
		end else if (too_low) begin
			grade.status = epfbm_pkg::STAT_LOW;
		end else begin
			grade.status  = epfbm_pkg::STAT_OK;
			grade.bar     = bar_new;
			grade.updated = 1'b1;
		end
	end

endmodule

// ===== verif/edge_period_frequency_bar_meter_tb.sv =====
// Self-checking testbench for the edge period frequency bar meter.
`timescale 1ns / 1ps

module edge_period_frequency_bar_meter_tb;
	import epfbm_pkg::*;

	localparam longint TICKS         = 1000000;
	localparam logic [63:0] BAR_MID  = 64'd7;
	localparam logic [63:0] BAR_BITS = 64'd16;
	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned PHASE_WORDS   = 150;

	typedef struct {
		kind_t       kind;
		logic [31:0] stamp;
	} meter_word_t;

	typedef struct {
		status_t              status;
		logic [FREQ_W-1:0]    freq;
		logic [BAR_OUT_W-1:0] bar;
		logic                 updated;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TDATA_IN_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = KIND_NOP;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_EDGES;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	edge_period_frequency_bar_meter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Register copies and measurement state of the predictor.
	logic [EDGES_W-1:0] reg_edges = EDGES_RST;
	logic [HZ_W-1:0] reg_max = MAX_RST;
	logic [HZ_W-1:0] reg_min = MIN_RST;
	logic [HZ_W-1:0] reg_center = CENTER_RST;
	logic meas_await = 1'b0;
	logic meas_done = 1'b1;
	logic [EDGES_W-1:0] meas_count = '0;
	logic [31:0] meas_start = '0;
	logic [31:0] meas_period = '0;
	logic [BAR_OUT_W-1:0] held_bar = '0;

	meter_word_t pending_words[$];
	reading_t readings_due[$];

	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	bit hold_req = 1'b0;
	int unsigned tx_gap_max = 15;
	int unsigned rx_gap_max = 15;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned fails = 0;
	int unsigned stim_count = 0;
	int unsigned words_taken = 0;
	int unsigned readings_checked = 0;
	int unsigned bar_updates = 0;
	int unsigned settings_done = 0;
	int unsigned holds_done = 0;
	int unsigned stat_seen[4] = '{0, 0, 0, 0};

	function automatic logic [BAR_OUT_W-1:0] bar_word(logic [63:0] num, logic [63:0] per,
			logic [HZ_W-1:0] centre);
		logic [63:0] cp;
		logic [63:0] diff;
		logic [63:0] mag;
		logic [63:0] pos;
		logic below;
		cp = 64'(centre) * per;
		below = num < cp;
		diff = below ? cp - num : num - cp;
		// Distance from the centre, rounded half away from zero.
		mag = (2 * diff + per) / (2 * per);
		if (below) begin
			if (mag > BAR_MID)
				return '0;
			pos = BAR_MID - mag;
		end else
			pos = BAR_MID + mag;
		if (pos >= BAR_BITS)
			return '0;
		return 16'(1) << pos;
	endfunction

	task automatic predict_word(kind_t kind, logic [31:0] stamp);
		reading_t r;
		logic [63:0] num;
		logic [63:0] per;
		logic [63:0] q;
		case (kind)
			KIND_START: begin
				meas_done = 1'b0;
				meas_await = 1'b1;
				meas_period = '0;
				meas_count = '0;
			end
			KIND_EDGE: begin
				if (meas_await) begin
					meas_start = stamp;
					meas_await = 1'b0;
				end else if (!meas_done) begin
					meas_count = meas_count + 5'd1;
					if (meas_count == reg_edges) begin
						meas_period = stamp - meas_start;
						meas_done = 1'b1;
					end
				end
			end
			KIND_EVAL: begin
				r.freq = '0;
				r.updated = 1'b0;
				if (meas_done) begin
					num = 64'(reg_edges) * 64'(TICKS);
					per = 64'(meas_period);
					if (per == 0) begin
						r.status = STAT_HIGH;
						r.freq = FREQ_Q8_MAX;
					end else begin
						q = (num * 256) / per;
						r.freq = (q > 64'(FREQ_Q8_MAX)) ? FREQ_Q8_MAX : q[FREQ_W-1:0];
						if (num > 64'(reg_max) * per)
							r.status = STAT_HIGH;
						else if (num < 64'(reg_min) * per)
							r.status = STAT_LOW;
						else begin
							r.status = STAT_OK;
							held_bar = bar_word(num, per, reg_center);
							r.updated = 1'b1;
						end
					end
				end else
					r.status = meas_await ? STAT_NOSIG : STAT_LOW;
				r.bar = held_bar;
				readings_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic check_reading(reading_t got);
		reading_t want;
		if (readings_due.size() == 0) begin
			$error("result word with no reading expected: status %0d freq %0d",
				got.status, got.freq);
			fails++;
		end else begin
			want = readings_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
			if (got.freq !== want.freq) begin
				$error("frequency_q8: expected %0d, got %0d", want.freq, got.freq);
				fails++;
			end
			if (got.bar !== want.bar) begin
				$error("bar_pattern: expected %h, got %h", want.bar, got.bar);
				fails++;
			end
			if (got.updated !== want.updated) begin
				$error("bar_updated: expected %0d, got %0d", want.updated, got.updated);
				fails++;
			end
		end
		readings_checked++;
		stat_seen[got.status]++;
		if (got.updated === 1'b1)
			bar_updates++;
	endtask

	// Both handshakes are sampled here; results are checked before the new input word is
	// predicted, as a result can never belong to a word taken at the same edge.
	always @(posedge clk) begin
		reading_t got;
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (out_taken) begin
			got.status = status_t'(m_tuser);
			got.freq = m_tdata[17:0];
			got.bar = m_tdata[33:18];
			got.updated = m_tdata[34];
			check_reading(got);
		end
		if (in_taken) begin
			predict_word(kind_t'(s_tuser), s_tdata);
			words_taken++;
		end
		if (in_taken || out_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no word moved for %0d cycles", STALL_LIMIT);
			$display("edge_period_frequency_bar_meter_tb: errors");
			$finish;
		end
	end

	// Sender: takes the next pending word once the current one is gone and its gap is over.
	always @(negedge clk) begin
		meter_word_t w;
		if (!arst_n)
			s_tvalid <= 1'b0;
		else if (!s_tvalid || in_taken) begin
			if (tx_wait > 0) begin
				tx_wait--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= w.stamp;
				s_tuser <= w.kind;
				tx_wait = $urandom_range(0, tx_gap_max);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Receiver: a fresh wait after each result word, and a long hold when asked for.
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			holds_done++;
			m_tready <= 1'b0;
		end else begin
			if (out_taken)
				rx_wait = $urandom_range(0, rx_gap_max);
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	task automatic push_word(kind_t kind, logic [31:0] stamp);
		meter_word_t w;
		w.kind = kind;
		w.stamp = stamp;
		pending_words.push_back(w);
		if (kind != KIND_NOP)
			stim_count++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_EDGES:  reg_edges = val[EDGES_W-1:0];
			REG_MAX:    reg_max = val;
			REG_MIN:    reg_min = val;
			REG_CENTER: reg_center = val;
		endcase
	endtask

	task automatic configure(logic [9:0] e, logic [9:0] mx, logic [9:0] mn, logic [9:0] c);
		write_reg(REG_EDGES, e);
		write_reg(REG_MAX, mx);
		write_reg(REG_MIN, mn);
		write_reg(REG_CENTER, c);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	// Waits until every word is taken and every reading has come, then lets the
	// meter settle.
	task automatic drain();
		while (pending_words.size() != 0 || s_tvalid || readings_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One measurement: start, first edge, counted edges, evaluate. A broken run stops
	// short of the full count.
	task automatic gen_run(bit broken);
		int unsigned n_edges;
		int unsigned total;
		int unsigned i;
		longint num;
		longint span;
		longint fq;
		logic [31:0] t0;
		logic [31:0] spacing;
		logic [31:0] stamp;
		num = longint'(reg_edges) * TICKS;
		n_edges = (reg_edges == 0) ? 32 : reg_edges;
		if (num == 0)
			span = longint'($urandom);
		else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					fq = longint'(reg_center) * 256 + longint'($urandom_range(0, 5120)) - 2560;
					if (fq < 1)
						fq = 1;
					span = num * 256 / fq;
				end
				4: span = num / ((reg_max == 0) ? 1 : reg_max) + $urandom_range(0, 2) - 1;
				5: span = num / ((reg_min == 0) ? 1 : reg_min) + $urandom_range(0, 2) - 1;
				6: span = $urandom_range(0, 64);
				7: span = longint'($urandom);
				default: begin
					fq = $urandom_range(1, 1100 * 256);
					span = num * 256 / fq;
				end
			endcase
		end
		t0 = $urandom;
		spacing = span[31:0] / n_edges;
		total = broken ? $urandom_range(0, n_edges) : n_edges + 1;
		push_word(KIND_START, $urandom);
		for (i = 0; i < total; i++) begin
			stamp = (i == n_edges) ? t0 + span[31:0] : t0 + spacing * i;
			push_word(KIND_EDGE, stamp);
			if ($urandom_range(0, 9) == 0)
				push_word(KIND_EVAL, $urandom);
		end
		push_word(KIND_EVAL, $urandom);
		if (!broken && $urandom_range(0, 3) == 0) begin
			push_word(KIND_EDGE, $urandom);
			push_word(KIND_EVAL, $urandom);
		end
	endtask

	initial begin
		int unsigned ph;
		int unsigned goal;
		int unsigned pick;
		logic [9:0] e;
		logic [9:0] mx;
		logic [9:0] mn;
		logic [9:0] c;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// One edge per period and a centre chosen so that 312.5 Hz sits exactly
		// half way between two bar positions.
		configure(10'd1, 10'd1000, 10'd1, 10'd310);
		push_word(KIND_EVAL, $urandom);          // zero period straight after reset
		push_word(KIND_EDGE, 32'hFFFF_FFFF);     // ignored while idle
		push_word(KIND_NOP, 32'hA5A5_A5A5);
		push_word(KIND_START, 32'h0);
		push_word(KIND_EVAL, $urandom);          // first edge still awaited
		push_word(KIND_EDGE, 32'hFFFF_FFFF);
		push_word(KIND_EVAL, $urandom);          // unfinished after the first edge
		push_word(KIND_EDGE, 32'd3199);          // timestamp wraps, period 3200
		push_word(KIND_EVAL, $urandom);
		push_word(KIND_EDGE, 32'd12345);         // ignored once the period is latched
		push_word(KIND_EVAL, $urandom);
		push_word(KIND_START, $urandom);
		push_word(KIND_EDGE, 32'd5);
		push_word(KIND_EDGE, 32'd5);             // zero period
		push_word(KIND_EVAL, $urandom);
		push_word(KIND_START, $urandom);
		push_word(KIND_EDGE, 32'd0);
		push_word(KIND_EDGE, 32'd1);             // saturated frequency, bar held
		push_word(KIND_EVAL, $urandom);
		push_word(KIND_START, $urandom);
		push_word(KIND_EDGE, 32'd0);
		push_word(KIND_EDGE, 32'hFFFF_FFFF);     // longest period, frequency floors to zero
		push_word(KIND_EVAL, $urandom);
		drain();

		// Two and a half positions below the centre, then exactly on the upper limit.
		configure(10'd1, 10'd1000, 10'd1, 10'd315);
		push_word(KIND_START, $urandom);
		push_word(KIND_EDGE, 32'd100);
		push_word(KIND_EDGE, 32'd3300);
		push_word(KIND_EVAL, $urandom);
		push_word(KIND_START, $urandom);
		push_word(KIND_EDGE, 32'd0);
		push_word(KIND_EDGE, 32'd1000);
		push_word(KIND_EVAL, $urandom);
		drain();

		for (ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin e = 10'd10; mx = 10'd400; mn = 10'd75; c = 10'd200; end
				1: begin e = 10'd16; mx = 10'd1000; mn = 10'd1; c = 10'd1000; end
				2: begin e = 10'd1; mx = 10'd1000; mn = 10'd1; c = 10'd8; end
				// Upper bits are masked off, leaving an edge count of zero that wraps.
				3: begin e = 10'h3E0; mx = 10'd400; mn = 10'd0; c = 10'd8; end
				4: begin e = 10'd3; mx = 10'd1; mn = 10'd1000; c = 10'd500; end
				5: begin e = 10'd2; mx = 10'd1000; mn = 10'd1000; c = 10'd1000; end
				default: begin
					e = {5'($urandom), 5'($urandom_range(1, 16))};
					mx = $urandom_range(1, 1000);
					mn = $urandom_range(1, mx);
					c = $urandom_range(8, 1000);
				end
			endcase
			tx_gap_max = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 0 : 4;
			rx_gap_max = (ph % 4 == 1) ? 0 : (ph % 4 == 3) ? 3 : 15;
			configure(e, mx, mn, c);
			if (ph == 2) begin
				// Stall the result side while words keep coming, so the input backs up.
				tx_gap_max = 0;
				hold_req = 1'b1;
			end
			goal = stim_count + PHASE_WORDS;
			while (stim_count < goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					gen_run(1'b0);
				else if (pick < 88)
					gen_run(1'b1);
				else
					repeat ($urandom_range(1, 4))
						push_word(kind_t'($urandom_range(0, 3)), $urandom);
			end
			drain();
		end

		$display("%0d words taken over %0d register settings, %0d long result holds",
			words_taken, settings_done, holds_done);
		$display("%0d readings: %0d in range, %0d high, %0d low, %0d no signal, %0d bar updates",
			readings_checked, stat_seen[0], stat_seen[1], stat_seen[2], stat_seen[3],
			bar_updates);
		if (fails == 0)
			$display("edge_period_frequency_bar_meter_tb: clean");
		else
			$display("edge_period_frequency_bar_meter_tb: errors");
		$finish;
	end

endmodule
